// File: src/ltc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ltc_pkg;
	typedef enum logic [2:0] {
		REQ_GET    = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_READY  = 3'd3,
		REQ_ERROR  = 3'd4,
		REQ_QUERY  = 3'd5,
		REQ_CLEAR  = 3'd6,
		REQ_NONE   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_NOTREADY = 2'd2
	} status_t;

	localparam logic [1:0] ES_NOT_READY = 2'd0;
	localparam logic [1:0] ES_READY     = 2'd1;
	localparam logic [1:0] ES_ERROR     = 2'd2;

	localparam int TAG_W   = 53;
	localparam int STAMP_W = 64;
	localparam logic [6:0] CAP_RESET = 7'd50;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [23:0] tile_x;
		logic [23:0] tile_y;
		logic [4:0]  tile_zoom;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  entry_state;
		logic [5:0]  slot_index;
		logic        evicted_valid;
		logic [23:0] evicted_x;
		logic [23:0] evicted_y;
		logic [4:0]  evicted_zoom;
		logic [6:0]  entry_count;
	} rsp_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_WAIT,
		BK_ACT,
		BK_LAST,
		BK_DONE
	} bk_state_t;
endpackage
`default_nettype wire

// File: src/ltc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ltc_req_if;
	logic              valid;
	logic              ready;
	ltc_pkg::req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ltc_rsp_if;
	logic              valid;
	logic              ready;
	ltc_pkg::rsp_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ltc_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/ltc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ltc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: src/ltc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module ltc_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire ltc_pkg::req_item_t in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      ltc_pkg::req_item_t out_data
);
	ltc_pkg::req_item_t buf_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: src/ltc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module ltc_engine #(
	parameter int ENTRIES = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [6:0]         cap,
	input  wire logic               req_valid,
	output      logic               req_ready,
	input  wire ltc_pkg::req_item_t req,
	output      logic               rsp_valid,
	input  wire logic               rsp_ready,
	output      ltc_pkg::rsp_item_t rsp
);
	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int MW = ltc_pkg::TAG_W + 2 + 2 * ltc_pkg::STAMP_W;

	ltc_pkg::bk_state_t state_q, state_d;
	ltc_pkg::req_item_t cur_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      count_q;
	logic [63:0]        stamp_q, now_q;
	logic [AW-1:0]      idx_q;
	logic               rd_live_q;
	logic [AW-1:0]      rd_idx_q;
	logic               best_v_q, lru_v_q;
	logic [AW-1:0]      best_q, lru_q;
	logic [63:0]        best_ins_q, lru_acc_q, lru_ins_q;
	logic [1:0]         best_st_q;
	logic [52:0]        lru_tag_q;
	logic [AW-1:0]      free_q;
	logic               free_v_q;
	ltc_pkg::rsp_item_t rsp_q;
	logic               rsp_v_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [MW-1:0] wdata, rdata;
	logic [AW-1:0] raddr;
	logic [52:0]   r_tag, key;
	logic [1:0]    r_st;
	logic [63:0]   r_acc, r_ins;
	logic          newest;
	logic          last_idx;
	logic [CW-1:0] lim;
	ltc_pkg::req_t rt;
	logic          fire;

	ltc_pkg::rsp_item_t rsp_d;
	logic [ENTRIES-1:0] valid_d;
	logic [CW-1:0]      count_d;

	assign {r_tag, r_st, r_acc, r_ins} = rdata;
	assign rt  = ltc_pkg::req_t'(cur_q.req_type);
	assign key = {cur_q.tile_zoom, cur_q.tile_y, cur_q.tile_x};
	assign newest = (rt != ltc_pkg::REQ_REMOVE);
	assign last_idx = (idx_q == AW'(ENTRIES - 1));
	assign lim = (int'(cap) > ENTRIES) ? CW'(ENTRIES) : CW'(cap);
	assign raddr = (state_q == ltc_pkg::BK_LAST) ? best_q : idx_q;

	ltc_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign req_ready = (state_q == ltc_pkg::BK_IDLE);
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// free slot after eviction, used by insert
	logic          ins_evict;
	logic [AW-1:0] ins_slot;
	logic          ins_ok;
	always_comb begin
		ins_evict = (count_q >= lim) && lru_v_q;
		if (ins_evict && (!free_v_q || lru_q < free_q)) begin
			ins_slot = lru_q;
			ins_ok   = 1'b1;
		end else begin
			ins_slot = free_q;
			ins_ok   = free_v_q;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = best_q;
		wdata   = {r_tag, r_st, r_acc, r_ins};
		case (state_q)
			ltc_pkg::BK_IDLE: if (req_valid) state_d = ltc_pkg::BK_SCAN;
			ltc_pkg::BK_SCAN: if (last_idx) state_d = ltc_pkg::BK_WAIT;
			ltc_pkg::BK_WAIT: state_d = ltc_pkg::BK_LAST;
			ltc_pkg::BK_LAST: state_d = ltc_pkg::BK_ACT;
			ltc_pkg::BK_ACT: begin
				if (!rsp_v_q || rsp_ready) state_d = ltc_pkg::BK_DONE;
			end
			ltc_pkg::BK_DONE: state_d = ltc_pkg::BK_IDLE;
			default: state_d = ltc_pkg::BK_IDLE;
		endcase
		// the read of best_q is issued in BK_LAST; data arrives in BK_ACT
		if (state_q == ltc_pkg::BK_ACT && state_d == ltc_pkg::BK_DONE) begin
			case (rt)
				ltc_pkg::REQ_GET: begin
					we    = best_v_q && best_st_q == ltc_pkg::ES_READY;
					wdata = {r_tag, r_st, now_q, r_ins};
				end
				ltc_pkg::REQ_READY, ltc_pkg::REQ_ERROR: begin
					we    = best_v_q;
					wdata = {r_tag, (rt == ltc_pkg::REQ_READY) ? ltc_pkg::ES_READY
						: ltc_pkg::ES_ERROR, r_acc, r_ins};
				end
				ltc_pkg::REQ_INSERT: begin
					we    = ins_ok;
					waddr = ins_slot;
					wdata = {key, ltc_pkg::ES_NOT_READY, now_q, now_q};
				end
				default: we = 1'b0;
			endcase
		end
	end

	assign fire = (state_q == ltc_pkg::BK_ACT) && (!rsp_v_q || rsp_ready);

	// result and entry updates for the finishing request
	always_comb begin
		rsp_d             = '0;
		rsp_d.status      = ltc_pkg::ST_NOTFOUND;
		rsp_d.entry_count = 7'(count_q);
		valid_d           = valid_q;
		count_d           = count_q;
		case (rt)
			ltc_pkg::REQ_GET: if (best_v_q) begin
				rsp_d.entry_state = best_st_q;
				rsp_d.slot_index  = 6'(best_q);
				rsp_d.status = (best_st_q == ltc_pkg::ES_READY) ?
					ltc_pkg::ST_OK : ltc_pkg::ST_NOTREADY;
			end
			ltc_pkg::REQ_QUERY: if (best_v_q) begin
				rsp_d.entry_state = best_st_q;
				rsp_d.slot_index  = 6'(best_q);
				rsp_d.status = ltc_pkg::ST_OK;
			end
			ltc_pkg::REQ_READY, ltc_pkg::REQ_ERROR: if (best_v_q) begin
				rsp_d.entry_state = (rt == ltc_pkg::REQ_READY) ?
					ltc_pkg::ES_READY : ltc_pkg::ES_ERROR;
				rsp_d.slot_index  = 6'(best_q);
				rsp_d.status = ltc_pkg::ST_OK;
			end
			ltc_pkg::REQ_REMOVE: if (best_v_q) begin
				rsp_d.entry_state = best_st_q;
				rsp_d.slot_index  = 6'(best_q);
				rsp_d.status = ltc_pkg::ST_OK;
				valid_d[best_q] = 1'b0;
				count_d = count_q - CW'(1);
				rsp_d.entry_count = 7'(count_d);
			end
			ltc_pkg::REQ_INSERT: begin
				if (ins_evict) begin
					valid_d[lru_q] = 1'b0;
					rsp_d.evicted_valid = 1'b1;
					rsp_d.evicted_x    = lru_tag_q[23:0];
					rsp_d.evicted_y    = lru_tag_q[47:24];
					rsp_d.evicted_zoom = lru_tag_q[52:48];
				end
				if (ins_ok) begin
					valid_d[ins_slot] = 1'b1;
					rsp_d.status     = ltc_pkg::ST_OK;
					rsp_d.slot_index = 6'(ins_slot);
				end
				count_d = count_q - CW'(ins_evict) + CW'(ins_ok);
				rsp_d.entry_count = 7'(count_d);
			end
			ltc_pkg::REQ_CLEAR: begin
				valid_d = '0;
				count_d = '0;
				rsp_d.status = ltc_pkg::ST_OK;
				rsp_d.entry_count = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ltc_pkg::BK_IDLE && req_valid) begin
			cur_q <= req;
			now_q <= stamp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ltc_pkg::BK_IDLE;
			valid_q   <= '0;
			count_q   <= '0;
			stamp_q   <= '0;
			idx_q     <= '0;
			rd_live_q <= 1'b0;
			rd_idx_q  <= '0;
			best_v_q  <= 1'b0;
			lru_v_q   <= 1'b0;
			free_v_q  <= 1'b0;
			best_q    <= '0;
			lru_q     <= '0;
			free_q    <= '0;
			best_ins_q <= '0;
			lru_acc_q <= '0;
			lru_ins_q <= '0;
			lru_tag_q <= '0;
			best_st_q <= '0;
			rsp_v_q   <= 1'b0;
			rsp_q     <= '0;
		end else begin
			state_q <= state_d;
			if (fire) rsp_v_q <= 1'b1;
			else if (rsp_v_q && rsp_ready) rsp_v_q <= 1'b0;
			rd_live_q <= (state_q == ltc_pkg::BK_SCAN);
			rd_idx_q  <= idx_q;
			case (state_q)
				ltc_pkg::BK_IDLE: begin
					idx_q    <= '0;
					best_v_q <= 1'b0;
					lru_v_q  <= 1'b0;
					free_v_q <= 1'b0;
					if (req_valid) stamp_q <= stamp_q + 64'd1;
				end
				ltc_pkg::BK_SCAN: if (!last_idx) idx_q <= idx_q + AW'(1);
				ltc_pkg::BK_LAST: idx_q <= best_q;
				default: ;
			endcase
			// compare stage on registered read data
			if (rd_live_q) begin
				if (valid_q[rd_idx_q]) begin
					if (r_tag == key && (!best_v_q ||
						(newest ? (r_ins > best_ins_q) : (r_ins < best_ins_q)))) begin
						best_v_q   <= 1'b1;
						best_q     <= rd_idx_q;
						best_ins_q <= r_ins;
						best_st_q  <= r_st;
					end
					if (!lru_v_q || r_acc < lru_acc_q ||
						(r_acc == lru_acc_q && r_ins < lru_ins_q)) begin
						lru_v_q   <= 1'b1;
						lru_q     <= rd_idx_q;
						lru_acc_q <= r_acc;
						lru_ins_q <= r_ins;
						lru_tag_q <= r_tag;
					end
				end else if (!free_v_q) begin
					free_v_q <= 1'b1;
					free_q   <= rd_idx_q;
				end
			end
			if (fire) begin
				rsp_q   <= rsp_d;
				valid_q <= valid_d;
				count_q <= count_d;
			end
		end
	end

`ifndef SYNTH
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CW'($countones(valid_q)))
		else $error("entry count out of step with valid bits");
	a_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ltc_pkg::BK_IDLE && req_valid) |=> stamp_q == $past(stamp_q) + 64'd1)
		else $error("stamp not advanced");
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !rd_live_q)
		else $error("scan active while idle");
`endif
endmodule
`default_nettype wire

// File: src/lru_tile_cache_tags.sv
`timescale 1ns / 1ps
`default_nettype none
// Requests are handled one at a time: the engine takes a new request only when idle,
// after the previous result is issued. Each request runs a full tag scan, which
// reads one entry per cycle from a single-port-read tag RAM.
// A two-entry queue decouples the request port from the scan engine.
// Reset (arst_n low): all entries invalid, stamp counter zero, capacity 50.
// Tag RAM contents are not reset; the scan reads every entry but compares only valid ones.
module lru_tile_cache_tags #(
	parameter int ENTRIES = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	ltc_req_if.sink  req,
	ltc_rsp_if.source rsp,
	ltc_cfg_if.sink  cfg
);
	logic [6:0]         cap_q;
	logic               q_valid, q_ready;
	ltc_pkg::req_item_t q_data;

	// capacity register, writes always accepted
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ltc_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// front: request queue
	ltc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	// back: scan and update engine
	ltc_engine #(.ENTRIES(ENTRIES)) u_engine (
		.clk(clk), .arst_n(arst_n), .cap(cap_q),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_data),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp.data)
	);
endmodule
`default_nettype wire

// File: bench/tb_lru_tile_cache_tags.sv
`timescale 1ns / 1ps
module tb_lru_tile_cache_tags;

	// Scoreboard: holds the predicted store and the queue of predicted results.
	class tag_scoreboard;
		bit          valid_q [64];
		bit [52:0]   tag_q [64];
		bit [1:0]    state_q [64];
		bit [63:0]   acc_q [64];
		bit [63:0]   ins_q [64];
		bit [63:0]   stamp;
		bit [6:0]    cap;
		ltc_pkg::rsp_item_t pending [$];
		int          errors;

		function void clear_all();
			foreach (valid_q[i]) valid_q[i] = 0;
			stamp = 0;
			cap = ltc_pkg::CAP_RESET;
			errors = 0;
		endfunction

		function int live_count();
			int n;
			n = 0;
			foreach (valid_q[i]) if (valid_q[i]) n++;
			return n;
		endfunction

		// newest: largest insert stamp, else smallest
		function int lookup(bit [52:0] t, bit newest);
			int b;
			b = -1;
			for (int i = 0; i < 64; i++) begin
				if (!valid_q[i] || tag_q[i] != t) continue;
				if (b < 0) b = i;
				else if (newest ? ins_q[i] > ins_q[b] : ins_q[i] < ins_q[b]) b = i;
			end
			return b;
		endfunction

		function void note_request(ltc_pkg::req_item_t r);
			ltc_pkg::rsp_item_t o;
			bit [52:0] t;
			bit [63:0] now;
			int m;
			int lim;
			t = {r.tile_zoom, r.tile_y, r.tile_x};
			now = stamp;
			stamp++;
			o = '0;
			o.status = ltc_pkg::ST_NOTFOUND;
			case (ltc_pkg::req_t'(r.req_type))
				ltc_pkg::REQ_GET: begin
					m = lookup(t, 1'b1);
					if (m >= 0) begin
						o.entry_state = state_q[m];
						o.slot_index = 6'(m);
						if (state_q[m] == ltc_pkg::ES_READY) begin
							o.status = ltc_pkg::ST_OK;
							acc_q[m] = now;
						end else o.status = ltc_pkg::ST_NOTREADY;
					end
				end
				ltc_pkg::REQ_INSERT: begin
					lim = (int'(cap) > 64) ? 64 : int'(cap);
					if (live_count() >= lim) begin
						m = -1;
						for (int i = 0; i < 64; i++) begin
							if (!valid_q[i]) continue;
							if (m < 0 || acc_q[i] < acc_q[m] ||
							    (acc_q[i] == acc_q[m] && ins_q[i] < ins_q[m])) m = i;
						end
						if (m >= 0) begin
							o.evicted_valid = 1;
							{o.evicted_zoom, o.evicted_y, o.evicted_x} = tag_q[m];
							valid_q[m] = 0;
						end
					end
					for (int i = 0; i < 64; i++) begin
						if (!valid_q[i]) begin
							valid_q[i] = 1;
							tag_q[i] = t;
							state_q[i] = ltc_pkg::ES_NOT_READY;
							acc_q[i] = now;
							ins_q[i] = now;
							o.slot_index = 6'(i);
							o.status = ltc_pkg::ST_OK;
							break;
						end
					end
				end
				ltc_pkg::REQ_REMOVE: begin
					m = lookup(t, 1'b0);
					if (m >= 0) begin
						o.status = ltc_pkg::ST_OK;
						o.entry_state = state_q[m];
						o.slot_index = 6'(m);
						valid_q[m] = 0;
					end
				end
				ltc_pkg::REQ_READY, ltc_pkg::REQ_ERROR, ltc_pkg::REQ_QUERY: begin
					m = lookup(t, 1'b1);
					if (m >= 0) begin
						if (r.req_type == ltc_pkg::REQ_READY) state_q[m] = ltc_pkg::ES_READY;
						else if (r.req_type == ltc_pkg::REQ_ERROR)
							state_q[m] = ltc_pkg::ES_ERROR;
						o.status = ltc_pkg::ST_OK;
						o.entry_state = state_q[m];
						o.slot_index = 6'(m);
					end
				end
				ltc_pkg::REQ_CLEAR: begin
					foreach (valid_q[i]) valid_q[i] = 0;
					o.status = ltc_pkg::ST_OK;
				end
				default: ;
			endcase
			o.entry_count = 7'(live_count());
			pending.push_back(o);
		endfunction

		function void check_result(ltc_pkg::rsp_item_t got);
			ltc_pkg::rsp_item_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: want st%0d es%0d sl%0d ev%0d %h/%h/%0d cnt%0d",
						want.status, want.entry_state, want.slot_index, want.evicted_valid,
						want.evicted_x, want.evicted_y, want.evicted_zoom, want.entry_count);
					$display("           got st%0d es%0d sl%0d ev%0d %h/%h/%0d cnt%0d",
						got.status, got.entry_state, got.slot_index, got.evicted_valid,
						got.evicted_x, got.evicted_y, got.evicted_zoom, got.entry_count);
				end
			end
		endfunction
	endclass

	localparam int LATENCY = 70;
	localparam longint CYCLE_LIMIT = 1600 * 4 * (LATENCY + 60) + 200000;

	logic clk;
	logic arst_n;
	ltc_req_if req ();
	ltc_rsp_if rsp ();
	ltc_cfg_if cfg ();
	tag_scoreboard sb;
	longint cycles;
	bit sink_run;

	lru_tile_cache_tags #(.ENTRIES(64)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// Small pool of keys so that matches, duplicates and evictions are common;
	// a share of full-range keys exercises every key bit.
	bit [52:0] key_pool [8];

	function automatic ltc_pkg::req_item_t make_req(int op);
		ltc_pkg::req_item_t r;
		r.req_type = 3'(op);
		if ($urandom_range(0, 9) < 8)
			{r.tile_zoom, r.tile_y, r.tile_x} = key_pool[$urandom_range(0, 7)];
		else begin
			r.tile_x = 24'($urandom);
			r.tile_y = 24'($urandom);
			r.tile_zoom = 5'($urandom_range(0, 31));
		end
		return r;
	endfunction

	// One request transfer; the prediction is made at the accepting edge.
	// Valid stays up into the next request when there is no gap.
	task automatic send_req(ltc_pkg::req_item_t r);
		int g;
		g = pick_gap();
		if (g != 0) begin
			req.valid <= 0;
			repeat (g) @(posedge clk);
		end
		req.valid <= 1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
	endtask

	// Register write, only with nothing in flight and the scan drained.
	task automatic write_cap(bit [6:0] v);
		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		cfg.valid <= 1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		sb.cap = v;
		cfg.valid <= 0;
	endtask

	// Result side: random stalls on ready, checked at each transfer.
	initial begin
		int g;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
			if (sink_run && $urandom_range(0, 99) < 70) rsp.ready <= 1;
			else begin
				rsp.ready <= 0;
				if ($urandom_range(0, 99) < 3) begin
					g = pick_gap();
					repeat (g) begin
						@(posedge clk);
						if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
					end
				end
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL lru_tile_cache_tags");
				$finish;
			end
		end
	end

	initial begin
		ltc_pkg::req_item_t r;
		int op;
		bit [6:0] caps [6];
		sb = new();
		sb.clear_all();
		sink_run = 1;
		req.valid = 0;
		req.data = '0;
		cfg.valid = 0;
		cfg.data = '0;
		arst_n = 0;
		foreach (key_pool[i])
			key_pool[i] = {5'($urandom_range(0, 24)), 24'($urandom), 24'($urandom)};
		key_pool[0] = '0;
		key_pool[1] = {5'd24, 24'hFFFFFF, 24'hFFFFFF};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: miss, insert duplicates, state changes, extremes of the key.
		send_req(make_req(ltc_pkg::REQ_GET));
		r = '0; r.req_type = ltc_pkg::REQ_INSERT; send_req(r);
		send_req(r);
		r.req_type = ltc_pkg::REQ_GET; send_req(r);
		r.req_type = ltc_pkg::REQ_READY; send_req(r);
		r.req_type = ltc_pkg::REQ_GET; send_req(r);
		r.req_type = ltc_pkg::REQ_ERROR; send_req(r);
		r.req_type = ltc_pkg::REQ_GET; send_req(r);
		r.req_type = ltc_pkg::REQ_QUERY; send_req(r);
		r.req_type = ltc_pkg::REQ_REMOVE; send_req(r);
		send_req(r);
		send_req(r);
		r = '1; r.req_type = ltc_pkg::REQ_INSERT; send_req(r);
		r.tile_zoom = 5'd24; send_req(r);
		r.req_type = ltc_pkg::REQ_QUERY; send_req(r);
		r.req_type = ltc_pkg::REQ_NONE; send_req(r);
		r.req_type = ltc_pkg::REQ_READY; r.tile_x = 24'd5; send_req(r);
		r.req_type = ltc_pkg::REQ_CLEAR; send_req(r);
		r.req_type = ltc_pkg::REQ_QUERY; send_req(r);

		// Tiny capacity and capacity zero: evictions on nearly every insert.
		write_cap(7'd1);
		for (int i = 0; i < 4; i++) send_req(make_req(ltc_pkg::REQ_INSERT));
		write_cap(7'd0);
		for (int i = 0; i < 3; i++) send_req(make_req(ltc_pkg::REQ_INSERT));

		// Random phases over several capacities, including above 64 and
		// lowered below the current count.
		caps = '{7'd4, 7'd127, 7'd64, 7'd2, 7'd50, 7'd17};
		foreach (caps[p]) begin
			write_cap(caps[p]);
			if (p == 3) sink_run = 1;
			for (int i = 0; i < 265; i++) begin
				op = $urandom_range(0, 99);
				if (op < 35) op = ltc_pkg::REQ_INSERT;
				else if (op < 55) op = ltc_pkg::REQ_GET;
				else if (op < 67) op = ltc_pkg::REQ_READY;
				else if (op < 73) op = ltc_pkg::REQ_ERROR;
				else if (op < 83) op = ltc_pkg::REQ_REMOVE;
				else if (op < 93) op = ltc_pkg::REQ_QUERY;
				else if (op < 96) op = ltc_pkg::REQ_NONE;
				else op = (i % 90 == 89) ? ltc_pkg::REQ_CLEAR : ltc_pkg::REQ_GET;
				send_req(make_req(op));
			end
		end

		req.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("PASS lru_tile_cache_tags");
		end else begin
			$display("FAIL lru_tile_cache_tags");
		end
		$finish;
	end
endmodule
